/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the keyed history ring.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every rising edge of clk outside of reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that cond is never true at a rising edge of clk outside of reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

/* hdl/khr_pkg.sv */
// Types and constants of the keyed history ring.
`timescale 1ns / 1ps
package khr_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = FILL_W + 1;

  localparam int KEY_W    = 32;
  localparam int TAG_W    = 64;
  localparam int SERIAL_W = 32;
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 16;
  localparam int CMD_W    = 2;

  localparam logic [KEY_W-1:0] KEY_MASK = 32'h5A5A_5A5A;

  // Remainder of a 33-bit sum by a 16-bit mode, one bit a cycle.
  localparam int DIV_W     = SERIAL_W + 1;
  localparam int DIV_STEPS = DIV_W;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUBLISH = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_INJECT_MODE  = 1'b0,
    REG_INJECT_PHASE = 1'b1
  } reg_idx_t;

  localparam int CNT_PUBLISHED = 0;
  localparam int CNT_CONSUMED  = 1;
  localparam int CNT_MISSED    = 2;
  localparam int CNT_EVICTED   = 3;
  localparam int CNT_CORRUPTED = 4;
  localparam int CNT_WANTED    = 5;
  localparam int CNT_NUM       = 6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WRITE,
    S_SCAN
  } state_t;

  // Sum of a ring index and an offset below the depth, folded back into the ring.
  function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] folded;
    folded = (sum >= SUM_W'(RING_DEPTH)) ? (sum - SUM_W'(RING_DEPTH)) : sum;
    return folded[IDX_W-1:0];
  endfunction

endpackage

/* hdl/keyed_history_ring_with_fault_inject.sv */
// Top level of the keyed history ring with fault injection on published keys.
`timescale 1ns / 1ps
// Usage
//   Command channel: drive command, frame_key, request_tag and wanted with
//   start high; the word is taken at a rising edge where busy is low.
//   busy stays high while the word is worked on.
//   Result channel: done is high for exactly one cycle; hit, found_request,
//   found_wanted, found_serial and the six event counters are valid in that
//   cycle. The receiver cannot stall: the result must be taken then. The
//   counters keep their value until the next command changes them.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 inject_mode, 1 inject_phase) at once. Write only while idle.
//   From accept to done: clear and an unused command finish from idle;
//   publish goes straight to the write state with injection off or in
//   mode 1, else through the modulo test (the remainder unit takes one
//   dividend bit a cycle, 33 bits); lookup walks up to fill entries (64
//   in a full ring) through the single memory read port, one entry a cycle.
//   A new command may be taken in the cycle done is high.
//   Reset clears the ring pointers, serial, counters and registers; the ring
//   memory itself is not cleared, the fill level guards every read.
module keyed_history_ring_with_fault_inject (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [khr_pkg::CMD_W-1:0]     command,
  input  logic [khr_pkg::KEY_W-1:0]     frame_key,
  input  logic [khr_pkg::TAG_W-1:0]     request_tag,
  input  logic                          wanted,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [khr_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output logic                          hit,
  output logic [khr_pkg::TAG_W-1:0]     found_request,
  output logic                          found_wanted,
  output logic [khr_pkg::SERIAL_W-1:0]  found_serial,
  output logic [khr_pkg::CNT_W-1:0]     published_count,
  output logic [khr_pkg::CNT_W-1:0]     consumed_count,
  output logic [khr_pkg::CNT_W-1:0]     missed_count,
  output logic [khr_pkg::CNT_W-1:0]     evicted_count,
  output logic [khr_pkg::CNT_W-1:0]     corrupted_count,
  output logic [khr_pkg::CNT_W-1:0]     wanted_count
);
  import khr_pkg::*;
  `include "assert_macros.svh"

  // Configuration registers.
  logic [CFG_W-1:0] inject_mode;
  logic [CFG_W-1:0] inject_phase;

  // Sequencer.
  state_t state, state_next;

  // Held command word.
  logic [KEY_W-1:0] key_r;
  logic [TAG_W-1:0] tag_r;
  logic             want_r;

  // Ring control and counters.
  logic [SERIAL_W-1:0] serial;
  logic [IDX_W-1:0]    oldest;
  logic [FILL_W-1:0]   fill;
  logic [CNT_W-1:0]    evc [CNT_NUM];

  // Remainder unit.
  logic [DIV_W-1:0]    div_q;
  logic [CFG_W-1:0]    rem;
  logic [DIVCNT_W-1:0] div_cnt;
  logic                inj;
  logic [CFG_W:0]      shifted;
  logic                rem_ge;
  logic [CFG_W-1:0]    rem_new;

  // Lookup walk.
  logic [FILL_W-1:0] scan_left;
  logic              rd_pend;
  logic              match;
  logic              issue;

  // Ring memory: one write port, one registered read port.
  logic [KEY_W-1:0]    key_mem  [RING_DEPTH];
  logic [TAG_W-1:0]    req_mem  [RING_DEPTH];
  logic                want_mem [RING_DEPTH];
  logic [SERIAL_W-1:0] ser_mem  [RING_DEPTH];
  logic [KEY_W-1:0]    rd_key;
  logic [TAG_W-1:0]    rd_req;
  logic                rd_want;
  logic [SERIAL_W-1:0] rd_ser;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic                wr_en;
  logic [KEY_W-1:0]    wr_key;
  logic                ring_full;
  logic                accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign ring_full = (fill >= FILL_W'(RING_DEPTH));

  // One restoring step: shift in the next dividend bit, subtract the mode if it fits.
  assign shifted = {rem, div_q[DIV_W-1]};
  assign rem_ge  = (shifted >= {1'b0, inject_mode});
  assign rem_new = rem_ge ? CFG_W'(shifted - {1'b0, inject_mode}) : shifted[CFG_W-1:0];

  // Newest entry sits at oldest + fill - 1; the walk goes down from there.
  assign rd_addr = ring_wrap(SUM_W'(oldest) + SUM_W'(scan_left) - SUM_W'(1));
  assign wr_addr = ring_full ? oldest : ring_wrap(SUM_W'(oldest) + SUM_W'(fill));
  assign wr_key  = inj ? (key_r ^ KEY_MASK) : key_r;
  assign wr_en   = (state == S_WRITE);

  assign match = (state == S_SCAN) && rd_pend && (rd_key == key_r);
  assign issue = (state == S_SCAN) && !match && (scan_left != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      req_mem[wr_addr]  <= tag_r;
      want_mem[wr_addr] <= want_r;
      ser_mem[wr_addr]  <= serial;
    end
    if (issue) begin
      rd_key  <= key_mem[rd_addr];
      rd_req  <= req_mem[rd_addr];
      rd_want <= want_mem[rd_addr];
      rd_ser  <= ser_mem[rd_addr];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      inject_mode  <= '0;
      inject_phase <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_INJECT_MODE:  inject_mode  <= cfg_data;
        REG_INJECT_PHASE: inject_phase <= cfg_data;
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_PUBLISH: begin
              state_next = (inject_mode > CFG_W'(1)) ? S_DIV : S_WRITE;
            end
            CMD_LOOKUP: state_next = S_SCAN;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (div_cnt == DIVCNT_W'(DIV_STEPS - 1)) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: state_next = S_IDLE;
      S_SCAN: begin
        if (match || (scan_left == '0)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      hit       <= 1'b0;
      serial    <= '0;
      oldest    <= '0;
      fill      <= '0;
      scan_left <= '0;
      rd_pend   <= 1'b0;
      for (int i = 0; i < CNT_NUM; i++) begin
        evc[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            key_r  <= frame_key;
            tag_r  <= request_tag;
            want_r <= wanted;
            case (command)
              CMD_PUBLISH: begin
                // Advance the serial now; the modulo test works on the new value.
                serial  <= serial + SERIAL_W'(1);
                div_q   <= {1'b0, serial + SERIAL_W'(1)} + DIV_W'(inject_phase);
                rem     <= '0;
                div_cnt <= '0;
                inj     <= (inject_mode == CFG_W'(1));
              end
              CMD_LOOKUP: begin
                scan_left <= fill;
                rd_pend   <= 1'b0;
              end
              CMD_CLEAR: begin
                // Empty the ring and zero the serial and counters; registers stay.
                serial <= '0;
                oldest <= '0;
                fill   <= '0;
                for (int i = 0; i < CNT_NUM; i++) begin
                  evc[i] <= '0;
                end
                done          <= 1'b1;
                hit           <= 1'b0;
                found_request <= '0;
                found_wanted  <= 1'b0;
                found_serial  <= '0;
              end
              default: begin
                // Unused command: report the counters, touch nothing.
                done          <= 1'b1;
                hit           <= 1'b0;
                found_request <= '0;
                found_wanted  <= 1'b0;
                found_serial  <= '0;
              end
            endcase
          end
        end
        S_DIV: begin
          rem     <= rem_new;
          div_q   <= div_q << 1;
          div_cnt <= div_cnt + DIVCNT_W'(1);
          if (div_cnt == DIVCNT_W'(DIV_STEPS - 1)) begin
            inj <= (rem_new == '0);
          end
        end
        S_WRITE: begin
          // Store the entry; on a full ring drop the oldest.
          if (ring_full) begin
            oldest <= (oldest == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest + IDX_W'(1);
            evc[CNT_EVICTED] <= evc[CNT_EVICTED] + CNT_W'(1);
          end else begin
            fill <= fill + FILL_W'(1);
          end
          if (inj) begin
            evc[CNT_CORRUPTED] <= evc[CNT_CORRUPTED] + CNT_W'(1);
          end
          if (want_r) begin
            evc[CNT_WANTED] <= evc[CNT_WANTED] + CNT_W'(1);
          end
          evc[CNT_PUBLISHED] <= evc[CNT_PUBLISHED] + CNT_W'(1);
          done          <= 1'b1;
          hit           <= 1'b0;
          found_request <= '0;
          found_wanted  <= 1'b0;
          found_serial  <= '0;
        end
        S_SCAN: begin
          if (match) begin
            evc[CNT_CONSUMED] <= evc[CNT_CONSUMED] + CNT_W'(1);
            done          <= 1'b1;
            hit           <= 1'b1;
            found_request <= rd_req;
            found_wanted  <= rd_want;
            found_serial  <= rd_ser;
          end else if (issue) begin
            scan_left <= scan_left - FILL_W'(1);
            rd_pend   <= 1'b1;
          end else begin
            evc[CNT_MISSED] <= evc[CNT_MISSED] + CNT_W'(1);
            done          <= 1'b1;
            hit           <= 1'b0;
            found_request <= '0;
            found_wanted  <= 1'b0;
            found_serial  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign published_count = evc[CNT_PUBLISHED];
  assign consumed_count  = evc[CNT_CONSUMED];
  assign missed_count    = evc[CNT_MISSED];
  assign evicted_count   = evc[CNT_EVICTED];
  assign corrupted_count = evc[CNT_CORRUPTED];
  assign wanted_count    = evc[CNT_WANTED];

  // A result is only raised while the sequencer is idle.
  `ASSERT_CLK(a_done_idle, clk, rst, done |-> (state == S_IDLE), "done outside idle")
  // A hit is raised only together with a result strobe; it holds until the next result.
  `ASSERT_CLK(a_hit_done, clk, rst, $rose(hit) |-> done, "hit without done")
  // An accepted word either finishes at once or keeps the block busy.
  `ASSERT_CLK(a_accept_prog, clk, rst, accept |=> (busy || done), "accepted word lost")
  // The fill level never runs past the ring depth.
  `ASSERT_NEVER(a_fill_bound, clk, rst, fill > FILL_W'(RING_DEPTH), "fill above depth")

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the keyed history ring with fault injection.
`timescale 1ns / 1ps
module tb_top;
  import khr_pkg::*;

  // Bound the run well above the slowest legal schedule: ~1850 words, each at
  // worst a full-ring lookup, plus sender gaps.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Quiet cycles after the last result.
  localparam int TAIL_CYCLES  = 80;
  localparam int MAX_REPORTS  = 10;
  localparam int POOL_SIZE    = 24;
  // The one command code that the block takes and ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic                          hit;
    logic [TAG_W-1:0]              found_request;
    logic                          found_wanted;
    logic [SERIAL_W-1:0]           found_serial;
    logic [CNT_NUM-1:0][CNT_W-1:0] counts;
  } ring_word_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     command;
  logic [KEY_W-1:0]     frame_key;
  logic [TAG_W-1:0]     request_tag;
  logic                 wanted;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  logic                 hit;
  logic [TAG_W-1:0]     found_request;
  logic                 found_wanted;
  logic [SERIAL_W-1:0]  found_serial;
  logic [CNT_W-1:0]     published_count;
  logic [CNT_W-1:0]     consumed_count;
  logic [CNT_W-1:0]     missed_count;
  logic [CNT_W-1:0]     evicted_count;
  logic [CNT_W-1:0]     corrupted_count;
  logic [CNT_W-1:0]     wanted_count;

  keyed_history_ring_with_fault_inject uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .frame_key       (frame_key),
    .request_tag     (request_tag),
    .wanted          (wanted),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .hit             (hit),
    .found_request   (found_request),
    .found_wanted    (found_wanted),
    .found_serial    (found_serial),
    .published_count (published_count),
    .consumed_count  (consumed_count),
    .missed_count    (missed_count),
    .evicted_count   (evicted_count),
    .corrupted_count (corrupted_count),
    .wanted_count    (wanted_count)
  );

  // Free-running 4 ns clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Ring predictor: a private copy of the history ring, its serial, its event
  // counters and the two injection registers.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]              hist_key    [RING_DEPTH];
  logic [TAG_W-1:0]              hist_tag    [RING_DEPTH];
  logic                          hist_wanted [RING_DEPTH];
  logic [SERIAL_W-1:0]           hist_serial [RING_DEPTH];
  int unsigned                   hist_oldest;
  int unsigned                   hist_fill;
  logic [SERIAL_W-1:0]           serial_now;
  logic [CNT_NUM-1:0][CNT_W-1:0] event_cnt;
  logic [CFG_W-1:0]              inject_mode_now;
  logic [CFG_W-1:0]              inject_phase_now;

  // Words whose results are still in flight, oldest first.
  ring_word_t expected_words[$];

  int        mismatches  = 0;
  int        cycle_count = 0;
  int        idle_pct    = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  ring_word_t seen_word;
  ring_word_t oldest_word;

  // Empty the ring and zero serial and counters; the stores keep stale data,
  // which the fill level hides.
  function automatic void wipe_history();
    hist_oldest = 0;
    hist_fill   = 0;
    serial_now  = '0;
    event_cnt   = '0;
  endfunction

  // Decide whether a freshly raised serial gets its key scrambled. The sum
  // carries into bit 32, so no wrap before the modulo.
  function automatic bit serial_is_scrambled(input logic [SERIAL_W-1:0] serial);
    logic [SERIAL_W:0] sum;
    logic [SERIAL_W:0] modulus;
    if (inject_mode_now == 1) return 1'b1;
    if (inject_mode_now == 0) return 1'b0;
    sum     = serial + inject_phase_now;
    modulus = inject_mode_now;
    return (sum % modulus) == 0;
  endfunction

  // Apply one accepted word to the predicted ring and return its result.
  function automatic ring_word_t predict_ring_word(input logic [CMD_W-1:0] cmd,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [TAG_W-1:0] tag,
                                                   input logic want);
    ring_word_t       w;
    logic [KEY_W-1:0] stored_key;
    int unsigned      slot;
    int unsigned      n;
    w = '0;
    case (cmd)
      CMD_PUBLISH: begin
        serial_now = serial_now + 1'b1;
        stored_key = key;
        if (serial_is_scrambled(serial_now)) begin
          stored_key = key ^ KEY_MASK;
          event_cnt[CNT_CORRUPTED] = event_cnt[CNT_CORRUPTED] + 1'b1;
        end
        // Full ring: overwrite the oldest entry and advance past it.
        if (hist_fill >= RING_DEPTH) begin
          slot        = hist_oldest;
          hist_oldest = (hist_oldest + 1) % RING_DEPTH;
          event_cnt[CNT_EVICTED] = event_cnt[CNT_EVICTED] + 1'b1;
        end else begin
          slot      = (hist_oldest + hist_fill) % RING_DEPTH;
          hist_fill = hist_fill + 1;
        end
        hist_key[slot]    = stored_key;
        hist_tag[slot]    = tag;
        hist_wanted[slot] = want;
        hist_serial[slot] = serial_now;
        event_cnt[CNT_PUBLISHED] = event_cnt[CNT_PUBLISHED] + 1'b1;
        if (want) event_cnt[CNT_WANTED] = event_cnt[CNT_WANTED] + 1'b1;
      end
      CMD_LOOKUP: begin
        // Walk newest to oldest; the first equal key wins.
        for (n = hist_fill; n > 0 && !w.hit; n--) begin
          slot = (hist_oldest + n - 1) % RING_DEPTH;
          if (hist_key[slot] == key) begin
            w.hit           = 1'b1;
            w.found_request = hist_tag[slot];
            w.found_wanted  = hist_wanted[slot];
            w.found_serial  = hist_serial[slot];
          end
        end
        if (w.hit) event_cnt[CNT_CONSUMED] = event_cnt[CNT_CONSUMED] + 1'b1;
        else       event_cnt[CNT_MISSED]   = event_cnt[CNT_MISSED] + 1'b1;
      end
      CMD_CLEAR: wipe_history();
      default: ;
    endcase
    w.counts = event_cnt;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every done cycle pops the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic string counter_name(input int idx);
    case (idx)
      CNT_PUBLISHED: return "published_count";
      CNT_CONSUMED:  return "consumed_count";
      CNT_MISSED:    return "missed_count";
      CNT_EVICTED:   return "evicted_count";
      CNT_CORRUPTED: return "corrupted_count";
      default:       return "wanted_count";
    endcase
  endfunction

  function automatic void report_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch @%0t %s: expected %h, got %h", $realtime, what, want, got);
  endfunction

  function automatic void compare_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      seen_word.hit           = hit;
      seen_word.found_request = found_request;
      seen_word.found_wanted  = found_wanted;
      seen_word.found_serial  = found_serial;
      seen_word.counts[CNT_PUBLISHED] = published_count;
      seen_word.counts[CNT_CONSUMED]  = consumed_count;
      seen_word.counts[CNT_MISSED]    = missed_count;
      seen_word.counts[CNT_EVICTED]   = evicted_count;
      seen_word.counts[CNT_CORRUPTED] = corrupted_count;
      seen_word.counts[CNT_WANTED]    = wanted_count;
      if (expected_words.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, {63'd0, done});
      end else begin
        oldest_word = expected_words.pop_front();
        compare_field("hit", oldest_word.hit, seen_word.hit);
        compare_field("found_request", oldest_word.found_request,
                      seen_word.found_request);
        compare_field("found_wanted", oldest_word.found_wanted, seen_word.found_wanted);
        compare_field("found_serial", oldest_word.found_serial, seen_word.found_serial);
        for (int i = 0; i < CNT_NUM; i++)
          compare_field(counter_name(i), oldest_word.counts[i], seen_word.counts[i]);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one command word, hold it until taken, log its expected result,
  // then drop start for a random gap when the sender is set to idle.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag, input logic want);
    start       <= 1'b1;
    command     <= cmd;
    frame_key   <= key;
    request_tag <= tag;
    wanted      <= want;
    do @(posedge clk); while (busy);
    expected_words.push_back(predict_ring_word(cmd, key, tag, want));
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drop start and hold until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Write both injection registers back to back; call only while idle.
  task automatic write_inject_regs(input logic [CFG_W-1:0] mode,
                                   input logic [CFG_W-1:0] phase);
    cfg_we    <= 1'b1;
    cfg_index <= REG_INJECT_MODE;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_index <= REG_INJECT_PHASE;
    cfg_data  <= phase;
    @(posedge clk);
    cfg_we <= 1'b0;
    inject_mode_now  = mode;
    inject_phase_now = phase;
  endtask

  function automatic logic [TAG_W-1:0] random_tag();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty ring right after reset: a lookup must miss; an unused code changes nothing.
  task automatic test_empty_ring();
    send_word(CMD_LOOKUP, 32'h0000_0000, '0, 1'b0);
    send_word(CMD_UNUSED, '1, '1, 1'b1);
  endtask

  // Field extremes, duplicate keys resolved to the newest, a plain miss.
  task automatic test_publish_lookup();
    send_word(CMD_PUBLISH, 32'h0000_0000, 64'h0, 1'b0);
    send_word(CMD_PUBLISH, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_word(CMD_PUBLISH, 32'h0000_1234, 64'hA5A5_0000_1111_2222, 1'b1);
    send_word(CMD_PUBLISH, 32'h0000_1234, 64'h5A5A_3333_4444_5555, 1'b0);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0);
    send_word(CMD_LOOKUP, 32'h0000_0000, '1, 1'b1);
    send_word(CMD_LOOKUP, 32'h0000_1234, '0, 1'b0);
    send_word(CMD_LOOKUP, 32'hDEAD_BEEF, '0, 1'b0);
    send_word(CMD_UNUSED, 32'h0000_1234, random_tag(), 1'b1);
  endtask

  // Clear empties the ring and restarts the serial at one.
  task automatic test_clear();
    send_word(CMD_CLEAR, $urandom, random_tag(), 1'b1);
    send_word(CMD_LOOKUP, 32'h0000_0000, '0, 1'b0);
    send_word(CMD_PUBLISH, 32'h0000_0077, random_tag(), 1'b1);
    send_word(CMD_LOOKUP, 32'h0000_0077, '0, 1'b0);
  endtask

  // Mode 1 scrambles every key; mode 2 with the largest phase picks by parity.
  task automatic test_injection();
    drain_results();
    write_inject_regs(16'd1, 16'd0);
    send_word(CMD_PUBLISH, 32'h0BAD_F00D, random_tag(), 1'b0);
    send_word(CMD_LOOKUP, 32'h0BAD_F00D, '0, 1'b0);
    send_word(CMD_LOOKUP, 32'h0BAD_F00D ^ KEY_MASK, '0, 1'b0);
    drain_results();
    write_inject_regs(16'd2, 16'hFFFF);
    send_word(CMD_PUBLISH, 32'h0000_1111, random_tag(), 1'b1);
    send_word(CMD_PUBLISH, 32'h0000_2222, random_tag(), 1'b0);
    send_word(CMD_LOOKUP, 32'h0000_1111, '0, 1'b0);
    send_word(CMD_LOOKUP, 32'h0000_2222, '0, 1'b0);
  endtask

  // Random traffic under one register setting. Keys come mostly from a small
  // pool so lookups hit, duplicates pile up and the ring overflows; clears are
  // rare so the ring fills past its depth between them.
  task automatic run_random_words(input int count, input int sender_idle,
                                  input logic [CFG_W-1:0] mode,
                                  input logic [CFG_W-1:0] phase);
    int               taken;
    int unsigned      pick;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    drain_results();
    write_inject_regs(mode, phase);
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    idle_pct = sender_idle;
    taken    = 0;
    while (taken < count) begin
      pick = $urandom_range(999);
      if (pick < 5)        cmd = CMD_CLEAR;
      else if (pick < 35)  cmd = CMD_UNUSED;
      else if (pick < 530) cmd = CMD_PUBLISH;
      else                 cmd = CMD_LOOKUP;
      key  = key_pool[$urandom_range(POOL_SIZE - 1)];
      pick = $urandom_range(99);
      if (pick < 18) key = $urandom;
      else if (cmd == CMD_LOOKUP && pick < 35) key = key ^ KEY_MASK;
      send_word(cmd, key, random_tag(), $urandom_range(1));
      if (cmd != CMD_UNUSED) taken++;
    end
    idle_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    command     <= CMD_PUBLISH;
    frame_key   <= '0;
    request_tag <= '0;
    wanted      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_INJECT_MODE;
    cfg_data    <= '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      hist_key[i]    = '0;
      hist_tag[i]    = '0;
      hist_wanted[i] = 1'b0;
      hist_serial[i] = '0;
    end
    wipe_history();
    inject_mode_now  = '0;
    inject_phase_now = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_ring();
    test_publish_lookup();
    test_clear();
    test_injection();

    // Sweep the injection settings, extremes included, across sender idling.
    run_random_words(300, 0, 16'd0, 16'd0);
    run_random_words(300, 77, 16'd1, 16'hFFFF);
    run_random_words(300, 28, 16'($urandom_range(9, 3)), 16'($urandom_range(16'hFFFF)));
    run_random_words(300, 0, 16'hFFFF, 16'hFFFF - 16'($urandom_range(40, 1)));
    run_random_words(300, 77, 16'd2, 16'd0);
    run_random_words(300, 28, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));

    // Hold quiet long enough to catch a stray done after the last result.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      mismatches += expected_words.size();
      $display("%0d results never arrived", expected_words.size());
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
